FILE: hdl/pctdq_pkg.sv
// shared constants, types and functions of the phase current to dq transform
`default_nettype none
package pctdq_pkg;

    localparam int ADC_WIDTH        = 12;
    localparam int SINE_TABLE_DEPTH = 512;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_W           = 18;
    localparam int DIFF_W           = ((ADC_WIDTH + 1 > 19) ? ADC_WIDTH + 1 : 19) + 1;
    localparam int PADDR_W          = 4;

    localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;
    localparam logic [15:0] QUARTER_TURN  = 16'd16384;

    // register indexes
    localparam logic [1:0] REG_ZERO_CODE = 2'd0;
    localparam logic [1:0] REG_SCALE     = 2'd1;
    localparam logic [1:0] REG_ROT_ZERO  = 2'd2;
    localparam logic [1:0] REG_POLES     = 2'd3;

    typedef struct packed {
        logic signed [18:0] zero_current_code;
        logic signed [23:0] amps_per_count;
        logic [15:0]        rotor_zero_offset;
        logic [6:0]         pole_pair_count;
    } t_cfg;

    typedef logic signed [SINE_W-1:0] t_sine_rom [SINE_TABLE_DEPTH];

    // quarter-wave sine in Q16 from a Taylor series in Q30
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [15:0] t);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        x  = (64'(t) * 64'd6746518852) >> 16;
        x2 = (x * x) >> 30;
        term = x;
        s = $signed(x);
        // odd-power terms with alternating signs, divisors (2n)(2n+1)
        term = ((term * x2) >> 30) / 64'd6;
        s = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        s = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        s = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        s = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        s = s - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        s = s + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        s = s - $signed(term);
        if (s < 0) begin
            s = 0;
        end
        s = (s + 64'sd8192) >>> 14;
        if (s > 64'sd65536) begin
            s = 64'sd65536;
        end
        return s[SINE_W-1:0];
    endfunction

    // table depth is a power of two, so the entry phase is a shift of the index
    function automatic t_sine_rom build_rom();
        t_sine_rom          rom;
        logic [15:0]        p;
        logic [SINE_W-1:0]  v;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            p = 16'(k) << (16 - SINE_IDX_W);
            if (p[14]) begin
                v = quarter_sine(QUARTER_TURN - {2'b00, p[13:0]});
            end else begin
                v = quarter_sine({2'b00, p[13:0]});
            end
            rom[k] = p[15] ? -$signed(v) : $signed(v);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // add half and floor-shift by 16
    function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
        return (v + 64'sd32768) >>> 16;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/pctdq_if.sv
// request channel interfaces for input samples and transform results
`default_nettype none
interface pctdq_in_if
    import pctdq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ADC_WIDTH-1:0] adc_u;
    logic [ADC_WIDTH-1:0] adc_v;
    logic [ADC_WIDTH-1:0] adc_w;
    logic [15:0]          encoder_position;
    modport source (output valid, adc_u, adc_v, adc_w, encoder_position, input ready);
    modport sink   (input valid, adc_u, adc_v, adc_w, encoder_position, output ready);
endinterface

interface pctdq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] current_u;
    logic signed [31:0] current_v;
    logic signed [31:0] current_w;
    logic signed [31:0] current_alpha;
    logic signed [31:0] current_beta;
    logic signed [31:0] current_direct;
    logic signed [31:0] current_quadrature;
    logic [15:0]        electrical_angle;
    modport source (output valid, current_u, current_v, current_w, current_alpha,
                    current_beta, current_direct, current_quadrature, electrical_angle,
                    input ready);
    modport sink   (input valid, current_u, current_v, current_w, current_alpha,
                    current_beta, current_direct, current_quadrature, electrical_angle,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/pctdq_cfg.sv
// apb configuration registers
`default_nettype none
module pctdq_cfg
    import pctdq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);
    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_current_code <= 19'sd2048;
            r_cfg.amps_per_count    <= 24'sd1000;
            r_cfg.rotor_zero_offset <= 16'd0;
            r_cfg.pole_pair_count   <= 7'd7;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_ZERO_CODE: r_cfg.zero_current_code <= pwdata[18:0];
                REG_SCALE:     r_cfg.amps_per_count    <= pwdata[23:0];
                REG_ROT_ZERO:  r_cfg.rotor_zero_offset <= pwdata[15:0];
                REG_POLES:     r_cfg.pole_pair_count   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            REG_ZERO_CODE: prdata = 32'(r_cfg.zero_current_code);
            REG_SCALE:     prdata = 32'(r_cfg.amps_per_count);
            REG_ROT_ZERO:  prdata = {16'd0, r_cfg.rotor_zero_offset};
            REG_POLES:     prdata = {25'd0, r_cfg.pole_pair_count};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

FILE: hdl/pctdq_front.sv
// stages 1-2: offset removal, scaling to amps and electrical angle
`default_nettype none
module pctdq_front
    import pctdq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire t_cfg                 i_cfg,
    input  wire logic [ADC_WIDTH-1:0] i_adc_u,
    input  wire logic [ADC_WIDTH-1:0] i_adc_v,
    input  wire logic [ADC_WIDTH-1:0] i_adc_w,
    input  wire logic [15:0]          i_enc,
    output logic                      o_valid,
    output logic signed [31:0]        o_iu,
    output logic signed [31:0]        o_iv,
    output logic signed [31:0]        o_iw,
    output logic [15:0]               o_elec
);
    logic                     r_v1, r_v2;
    logic signed [DIFF_W-1:0] r_du, r_dv, r_dw;
    logic [15:0]              r_mech;
    logic signed [31:0]       r_iu, r_iv, r_iw;
    logic [15:0]              r_elec;
    logic [22:0]              w_ang;

    function automatic logic signed [DIFF_W-1:0] code_diff(
        input logic [ADC_WIDTH-1:0] code, input logic signed [18:0] zero);
        return $signed({{(DIFF_W-ADC_WIDTH){1'b0}}, code}) - DIFF_W'(zero);
    endfunction

    function automatic logic signed [31:0] scale(
        input logic signed [DIFF_W-1:0] d, input logic signed [23:0] k);
        return sat32(64'(d) * 64'(k));
    endfunction

    assign w_ang = r_mech * i_cfg.pole_pair_count;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_du   <= code_diff(i_adc_u, i_cfg.zero_current_code);
            r_dv   <= code_diff(i_adc_v, i_cfg.zero_current_code);
            r_dw   <= code_diff(i_adc_w, i_cfg.zero_current_code);
            r_mech <= i_enc - i_cfg.rotor_zero_offset;
            r_iu   <= scale(r_du, i_cfg.amps_per_count);
            r_iv   <= scale(r_dv, i_cfg.amps_per_count);
            r_iw   <= scale(r_dw, i_cfg.amps_per_count);
            r_elec <= w_ang[15:0];
        end
    end

    assign o_valid = r_v2;
    assign o_iu    = r_iu;
    assign o_iv    = r_iv;
    assign o_iw    = r_iw;
    assign o_elec  = r_elec;
endmodule
`default_nettype wire

FILE: hdl/pctdq_park.sv
// stages 3-6: clarke beta, sine lookup, park products and rounding
`default_nettype none
module pctdq_park
    import pctdq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_iu,
    input  wire logic signed [31:0] i_iv,
    input  wire logic signed [31:0] i_iw,
    input  wire logic [15:0]        i_elec,
    output logic                    o_valid,
    output logic signed [31:0]      o_iu,
    output logic signed [31:0]      o_iv,
    output logic signed [31:0]      o_iw,
    output logic signed [31:0]      o_beta,
    output logic signed [31:0]      o_d,
    output logic signed [31:0]      o_q,
    output logic [15:0]             o_elec
);
    logic [3:0] r_v;

    // pass-through fields per stage
    logic signed [31:0] r_iu [4];
    logic signed [31:0] r_iv [4];
    logic signed [31:0] r_iw [4];
    logic [15:0]        r_el [4];

    logic signed [63:0]       r_bprod;
    logic signed [SINE_W-1:0] r_sn3, r_cs3, r_sn4, r_cs4;
    logic signed [31:0]       r_beta4, r_beta5, r_beta6;
    logic signed [63:0]       r_ac, r_bs, r_bc, r_as;
    logic signed [31:0]       r_d, r_q;

    logic [15:0]        w_cos_ang;
    logic signed [63:0] w_sum;

    assign w_cos_ang = i_elec + QUARTER_TURN;
    assign w_sum     = 64'(i_iu) + (64'(i_iv) <<< 1);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_iu[0] <= i_iu;
            r_iv[0] <= i_iv;
            r_iw[0] <= i_iw;
            r_el[0] <= i_elec;
            for (int k = 1; k < 4; k++) begin
                r_iu[k] <= r_iu[k-1];
                r_iv[k] <= r_iv[k-1];
                r_iw[k] <= r_iw[k-1];
                r_el[k] <= r_el[k-1];
            end
            // stage 3: beta product and table lookup
            r_bprod <= w_sum * 64'(INV_SQRT3_Q16);
            r_sn3   <= SINE_ROM[i_elec[15 -: SINE_IDX_W]];
            r_cs3   <= SINE_ROM[w_cos_ang[15 -: SINE_IDX_W]];
            // stage 4: round beta
            r_beta4 <= sat32(round_q16(r_bprod));
            r_sn4   <= r_sn3;
            r_cs4   <= r_cs3;
            // stage 5: park products, alpha equals phase u
            r_ac    <= 64'(r_iu[1]) * 64'(r_cs4);
            r_bs    <= 64'(r_beta4) * 64'(r_sn4);
            r_bc    <= 64'(r_beta4) * 64'(r_cs4);
            r_as    <= 64'(r_iu[1]) * 64'(r_sn4);
            r_beta5 <= r_beta4;
            // stage 6: sum, round, saturate
            r_d     <= sat32(round_q16(r_ac + r_bs));
            r_q     <= sat32(round_q16(r_bc - r_as));
            r_beta6 <= r_beta5;
        end
    end

    assign o_valid = r_v[3];
    assign o_iu    = r_iu[3];
    assign o_iv    = r_iv[3];
    assign o_iw    = r_iw[3];
    assign o_beta  = r_beta6;
    assign o_d     = r_d;
    assign o_q     = r_q;
    assign o_elec  = r_el[3];
endmodule
`default_nettype wire

FILE: hdl/phase_current_to_dq_transform.sv
// pipeline: two front stages and four park stages lie between accepted request and result valid
// throughput: one request per cycle; the whole pipeline holds while a result waits
// stall: ready drops only while the output register holds a result not yet taken
// reset: synchronous active low, clears all valid bits and loads register defaults
// no clearing pass: the sine table is a constant
`default_nettype none
module phase_current_to_dq_transform
    import pctdq_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    pctdq_in_if.sink                i_in,
    pctdq_out_if.source             o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);
    t_cfg               w_cfg;
    logic               w_en;
    logic               w_fv;
    logic signed [31:0] w_iu, w_iv, w_iw;
    logic [15:0]        w_el;

    // pipeline advances unless the output holds an untaken result
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    pctdq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pctdq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_cfg   (w_cfg),
        .i_adc_u (i_in.adc_u),
        .i_adc_v (i_in.adc_v),
        .i_adc_w (i_in.adc_w),
        .i_enc   (i_in.encoder_position),
        .o_valid (w_fv),
        .o_iu    (w_iu),
        .o_iv    (w_iv),
        .o_iw    (w_iw),
        .o_elec  (w_el)
    );

    pctdq_park u_park (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_iu    (w_iu),
        .i_iv    (w_iv),
        .i_iw    (w_iw),
        .i_elec  (w_el),
        .o_valid (o_out.valid),
        .o_iu    (o_out.current_u),
        .o_iv    (o_out.current_v),
        .o_iw    (o_out.current_w),
        .o_beta  (o_out.current_beta),
        .o_d     (o_out.current_direct),
        .o_q     (o_out.current_quadrature),
        .o_elec  (o_out.electrical_angle)
    );

    assign o_out.current_alpha = o_out.current_u;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result stalled");
    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");
    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> u_front.r_v1)
        else $error("accepted request lost in first stage");
`endif
endmodule
`default_nettype wire
